FILE: sv/debc_pkg.sv
// ----------------------------------------------------------------------------
// debc_pkg
// Shared types and constants of the event debounce coalescer.
// ----------------------------------------------------------------------------
package debc_pkg;

    localparam int KIND_W      = 2;
    localparam int CH_W        = 3;
    localparam int SEC_W       = 16;
    localparam int RES_W       = 3;
    localparam int MAX_RESULTS = 8;
    localparam int CNT_W       = 4;

    typedef enum logic [KIND_W-1:0] {
        KIND_SUBMIT = 2'd0,
        KIND_CANCEL = 2'd1,
        KIND_TICK   = 2'd2,
        KIND_NONE   = 2'd3
    } kind_t;

    typedef enum logic [RES_W-1:0] {
        RES_LEAD   = 3'd0,
        RES_COAL   = 3'd1,
        RES_TRAIL  = 3'd2,
        RES_CEIL   = 3'd3,
        RES_CANCEL = 3'd4,
        RES_MISS   = 3'd5,
        RES_IDLE   = 3'd6
    } res_t;

    typedef enum logic [1:0] {
        ACT_DROP,
        ACT_TRAIL,
        ACT_CEIL,
        ACT_REARM
    } act_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SUM,
        ST_DIFF,
        ST_DEC,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic take;
        logic sum;
        logic diff;
        logic dec;
        logic commit;
        logic fin;
    } ctrl_cmd_t;

    typedef struct packed {
        logic out_free;
        logic in_tick;
        logic wr_stall;
        logic last_chan;
    } dp_stat_t;

endpackage

FILE: sv/debc_in_if.sv
// ----------------------------------------------------------------------------
// debc_in_if
// Request channel: one word is a submit, cancel or tick item.
// ----------------------------------------------------------------------------
interface debc_in_if;
    import debc_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [CH_W-1:0]   channel;
    logic [SEC_W-1:0]  grace_seconds;
    logic [SEC_W-1:0]  ceiling_seconds;

    modport source (output valid, kind, channel, grace_seconds, ceiling_seconds,
                    input ready);
    modport sink   (input valid, kind, channel, grace_seconds, ceiling_seconds,
                    output ready);
endinterface

FILE: sv/debc_out_if.sv
// ----------------------------------------------------------------------------
// debc_out_if
// Result channel: one word is one result of an item.
// ----------------------------------------------------------------------------
interface debc_out_if;
    import debc_pkg::*;

    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  out_channel;
    logic [RES_W-1:0] event_res;
    logic             last;

    modport source (output valid, out_channel, event_res, last, input ready);
    modport sink   (input valid, out_channel, event_res, last, output ready);
endinterface

FILE: sv/event_debounce_coalescer.sv
// ----------------------------------------------------------------------------
// event_debounce_coalescer
// Per-channel debouncer with leading, trailing and ceiling fires.
// ----------------------------------------------------------------------------
// Submit, cancel and unknown kinds: one result word, registered in the cycle after acceptance.
// Tick: a scan per channel through the channel stores (read, sum, compare,
//   decide, write), then a finish step for the last word; the write and
//   finish steps wait while the result side stalls.
// Reset clears time, active and pending flags; the time stores are not cleared.
// ----------------------------------------------------------------------------
module event_debounce_coalescer #(
    parameter int NUM_CHANNELS = 8,
    parameter int TIME_WIDTH   = 32
)
(
    input logic        clk,
    input logic        rst_n,
    debc_in_if.sink    req,
    debc_out_if.source rsp
);
    import debc_pkg::*;

    ctrl_cmd_t cmd;
    dp_stat_t  stat;

    debc_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    debc_dp #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .TIME_WIDTH   (TIME_WIDTH)
    ) u_dp
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .req_kind      (req.kind),
        .req_channel   (req.channel),
        .req_grace     (req.grace_seconds),
        .req_ceiling   (req.ceiling_seconds),
        .rsp_valid     (rsp.valid),
        .rsp_ready     (rsp.ready),
        .rsp_channel   (rsp.out_channel),
        .rsp_event_res (rsp.event_res),
        .rsp_last      (rsp.last)
    );

    a_tick_busy: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take && (req.kind == KIND_TICK) |=> !req.ready)
        else $error("request taken during tick scan");

    a_take_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.take |-> (!rsp.valid || rsp.ready))
        else $error("item taken with result word blocked");

    a_word_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(rsp.valid) |-> $past(cmd.take || cmd.commit || cmd.fin))
        else $error("result word without a source");

endmodule

FILE: sv/debc_ctrl.sv
// ----------------------------------------------------------------------------
// debc_ctrl
// Controller: accepts items and sequences the per-channel tick scan.
// ----------------------------------------------------------------------------
module debc_ctrl
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  debc_pkg::dp_stat_t   stat,
    output debc_pkg::ctrl_cmd_t  cmd
);
    import debc_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                req_ready = stat.out_free;
                if (req_valid && stat.out_free)
                begin
                    cmd.take = 1'b1;
                    if (stat.in_tick)
                    begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = ST_DIFF;
            end
            ST_DIFF:
            begin
                cmd.diff   = 1'b1;
                state_next = ST_DEC;
            end
            ST_DEC:
            begin
                cmd.dec    = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                if (!stat.wr_stall)
                begin
                    cmd.commit = 1'b1;
                    state_next = stat.last_chan ? ST_FINISH : ST_READ;
                end
            end
            ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.fin    = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: sv/debc_dp.sv
// ----------------------------------------------------------------------------
// debc_dp
// Datapath: channel flags, channel time stores, scan pipeline registers,
// held fire and result register.
// ----------------------------------------------------------------------------
module debc_dp #(
    parameter int NUM_CHANNELS = 8,
    parameter int TIME_WIDTH   = 32
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  debc_pkg::ctrl_cmd_t           cmd,
    output debc_pkg::dp_stat_t            stat,
    input  logic [debc_pkg::KIND_W-1:0]   req_kind,
    input  logic [debc_pkg::CH_W-1:0]     req_channel,
    input  logic [debc_pkg::SEC_W-1:0]    req_grace,
    input  logic [debc_pkg::SEC_W-1:0]    req_ceiling,
    output logic                          rsp_valid,
    input  logic                          rsp_ready,
    output logic [debc_pkg::CH_W-1:0]     rsp_channel,
    output logic [debc_pkg::RES_W-1:0]    rsp_event_res,
    output logic                          rsp_last
);
    import debc_pkg::*;

    localparam int IW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int TW = TIME_WIDTH;

    logic [TW-1:0]           now_reg;
    logic [NUM_CHANNELS-1:0] active_reg;
    logic [NUM_CHANNELS-1:0] pending_reg;
    logic [IW-1:0]           idx_reg;

    logic [SEC_W-1:0] grace_mem [NUM_CHANNELS];
    logic [SEC_W-1:0] ceil_mem  [NUM_CHANNELS];
    logic [TW-1:0]    lfire_mem [NUM_CHANNELS];
    logic [TW-1:0]    lsub_mem  [NUM_CHANNELS];
    logic [TW-1:0]    dl_mem    [NUM_CHANNELS];

    logic [SEC_W-1:0] grace_rd_reg;
    logic [SEC_W-1:0] ceil_rd_reg;
    logic [TW-1:0]    lfire_rd_reg;
    logic [TW-1:0]    lsub_rd_reg;
    logic [TW-1:0]    dl_rd_reg;

    logic [TW-1:0] g_reg;
    logic [TW-1:0] c_reg;
    logic          due_reg;
    logic          pend_reg;
    logic          at_g_reg;
    logic          at_c_reg;
    logic [TW-1:0] ag_reg;
    logic [TW-1:0] ac_reg;
    act_t          act_reg;
    logic [TW-1:0] dmin_reg;

    logic             hold_vld_reg;
    logic [CH_W-1:0]  hold_ch_reg;
    res_t             hold_res_reg;
    logic [CNT_W-1:0] cnt_reg;

    logic             out_vld_reg;
    logic [CH_W-1:0]  out_ch_reg;
    res_t             out_res_reg;
    logic             out_last_reg;

    logic             in_range;
    logic [IW-1:0]    in_idx;
    logic             in_active;
    logic [SEC_W-1:0] g_cl;
    logic [SEC_W-1:0] c_cl;
    logic             is_tick;
    logic             act_new;
    logic             coal;
    logic             cancel_hit;
    res_t             imm_res;
    logic [IW-1:0]    wr_idx;
    logic             out_free;
    logic             fire_type;
    logic             keep;
    logic             do_wr;
    logic [TW-1:0]    dl_diff;
    logic [TW-1:0]    ng;
    logic [TW-1:0]    gn;
    logic [TW-1:0]    nc;
    logic [TW-1:0]    cn;
    act_t             act_next;
    logic [TW-1:0]    ac_eff;

    // Request decode
    assign in_range   = int'(req_channel) < NUM_CHANNELS;
    assign in_idx     = IW'(req_channel);
    assign in_active  = in_range && active_reg[in_idx];
    assign g_cl       = (req_grace == '0) ? SEC_W'(1) : req_grace;
    assign c_cl       = (req_ceiling < g_cl) ? g_cl : req_ceiling;
    assign is_tick    = (req_kind == KIND_TICK);
    assign act_new    = cmd.take && (req_kind == KIND_SUBMIT) && in_range && !in_active;
    assign coal       = cmd.take && (req_kind == KIND_SUBMIT) && in_active;
    assign cancel_hit = cmd.take && (req_kind == KIND_CANCEL) && in_active;

    always_comb
    begin
        case (kind_t'(req_kind))
            KIND_SUBMIT: imm_res = !in_range ? RES_IDLE : (in_active ? RES_COAL : RES_LEAD);
            KIND_CANCEL: imm_res = in_active ? RES_CANCEL : RES_MISS;
            default:     imm_res = RES_IDLE;
        endcase
    end

    // Scan write side
    assign do_wr     = cmd.commit && due_reg;
    assign fire_type = (act_reg == ACT_TRAIL) || (act_reg == ACT_CEIL);
    assign keep      = do_wr && fire_type && (cnt_reg < CNT_W'(MAX_RESULTS));
    assign out_free  = !out_vld_reg || rsp_ready;
    assign wr_idx    = cmd.take ? in_idx : idx_reg;

    assign stat.out_free  = out_free;
    assign stat.in_tick   = is_tick;
    assign stat.wr_stall  = due_reg && fire_type && (cnt_reg < CNT_W'(MAX_RESULTS))
                            && hold_vld_reg && !out_free;
    assign stat.last_chan = (idx_reg == IW'(NUM_CHANNELS - 1));

    // Channel stores
    always_ff @(posedge clk)
    begin
        if (act_new)
        begin
            grace_mem[wr_idx] <= g_cl;
            ceil_mem[wr_idx]  <= c_cl;
        end
        grace_rd_reg <= grace_mem[idx_reg];
        ceil_rd_reg  <= ceil_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (act_new || coal)
        begin
            lsub_mem[wr_idx] <= now_reg;
        end
        lsub_rd_reg <= lsub_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (act_new || (do_wr && act_reg == ACT_CEIL))
        begin
            lfire_mem[wr_idx] <= now_reg;
        end
        lfire_rd_reg <= lfire_mem[idx_reg];
    end

    always_ff @(posedge clk)
    begin
        if (act_new)
        begin
            dl_mem[wr_idx] <= now_reg + TW'(g_cl);
        end
        else if (do_wr && (act_reg == ACT_CEIL || act_reg == ACT_REARM))
        begin
            dl_mem[wr_idx] <= now_reg + dmin_reg;
        end
        dl_rd_reg <= dl_mem[idx_reg];
    end

    // Scan pipeline
    assign dl_diff = now_reg - dl_rd_reg;
    assign ng      = now_reg - g_reg;
    assign gn      = g_reg - now_reg;
    assign nc      = now_reg - c_reg;
    assign cn      = c_reg - now_reg;

    always_comb
    begin
        if (!pend_reg && at_g_reg)
        begin
            act_next = ACT_DROP;
        end
        else if (pend_reg && at_g_reg)
        begin
            act_next = ACT_TRAIL;
        end
        else if (pend_reg && at_c_reg)
        begin
            act_next = ACT_CEIL;
        end
        else
        begin
            act_next = ACT_REARM;
        end
    end

    assign ac_eff = (act_next == ACT_CEIL) ? TW'(ceil_rd_reg) : ac_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.sum)
        begin
            g_reg    <= lsub_rd_reg + TW'(grace_rd_reg);
            c_reg    <= lfire_rd_reg + TW'(ceil_rd_reg);
            due_reg  <= active_reg[idx_reg] && !dl_diff[TW-1];
            pend_reg <= pending_reg[idx_reg];
        end
        if (cmd.diff)
        begin
            at_g_reg <= !ng[TW-1];
            at_c_reg <= !nc[TW-1];
            ag_reg   <= (gn == '0 || gn[TW-1]) ? TW'(1) : gn;
            ac_reg   <= (cn == '0 || cn[TW-1]) ? TW'(1) : cn;
        end
        if (cmd.dec)
        begin
            act_reg  <= act_next;
            dmin_reg <= (ag_reg < ac_eff) ? ag_reg : ac_eff;
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            now_reg      <= '0;
            active_reg   <= '0;
            pending_reg  <= '0;
            idx_reg      <= '0;
            hold_vld_reg <= 1'b0;
            cnt_reg      <= '0;
            out_vld_reg  <= 1'b0;
        end
        else
        begin
            if (act_new)
            begin
                active_reg[in_idx]  <= 1'b1;
                pending_reg[in_idx] <= 1'b0;
            end
            if (coal)
            begin
                pending_reg[in_idx] <= 1'b1;
            end
            if (cancel_hit)
            begin
                active_reg[in_idx]  <= 1'b0;
                pending_reg[in_idx] <= 1'b0;
            end
            if (do_wr)
            begin
                case (act_reg)
                    ACT_DROP:
                    begin
                        active_reg[idx_reg] <= 1'b0;
                    end
                    ACT_TRAIL:
                    begin
                        active_reg[idx_reg]  <= 1'b0;
                        pending_reg[idx_reg] <= 1'b0;
                    end
                    ACT_CEIL:
                    begin
                        pending_reg[idx_reg] <= 1'b0;
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cmd.take && is_tick)
            begin
                now_reg      <= now_reg + TW'(1);
                idx_reg      <= '0;
                hold_vld_reg <= 1'b0;
                cnt_reg      <= '0;
            end
            else
            begin
                if (cmd.commit && !stat.last_chan)
                begin
                    idx_reg <= idx_reg + IW'(1);
                end
                if (keep)
                begin
                    hold_vld_reg <= 1'b1;
                    cnt_reg      <= cnt_reg + CNT_W'(1);
                end
            end

            if ((cmd.take && !is_tick) || (keep && hold_vld_reg) || cmd.fin)
            begin
                out_vld_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // Held fire and result word
    always_ff @(posedge clk)
    begin
        if (keep)
        begin
            hold_ch_reg  <= CH_W'(idx_reg);
            hold_res_reg <= (act_reg == ACT_TRAIL) ? RES_TRAIL : RES_CEIL;
        end
        if (cmd.take && !is_tick)
        begin
            out_ch_reg   <= req_channel;
            out_res_reg  <= imm_res;
            out_last_reg <= 1'b1;
        end
        else if (keep && hold_vld_reg)
        begin
            out_ch_reg   <= hold_ch_reg;
            out_res_reg  <= hold_res_reg;
            out_last_reg <= 1'b0;
        end
        else if (cmd.fin)
        begin
            out_ch_reg   <= hold_vld_reg ? hold_ch_reg : '0;
            out_res_reg  <= hold_vld_reg ? hold_res_reg : RES_IDLE;
            out_last_reg <= 1'b1;
        end
    end

    assign rsp_valid     = out_vld_reg;
    assign rsp_channel   = out_ch_reg;
    assign rsp_event_res = out_res_reg;
    assign rsp_last      = out_last_reg;

endmodule

FILE: verif/tb_event_debounce_coalescer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_event_debounce_coalescer
// Drives submit, cancel, tick and unknown-kind words into the debouncer while
// both sides idle at random and the result side holds off once for a long
// stretch. A directed table covers clamping, every result code and
// multi-channel ticks; random traffic on short windows follows. Typed rows
// are checked as written, other words against a cycle-free channel predictor.
// ----------------------------------------------------------------------------
module tb_event_debounce_coalescer;
    import debc_pkg::*;

    localparam int NCH = 8;
    localparam int TW  = 32;
    localparam int RANDOM_ITEMS = 260;

    typedef struct packed {
        logic [CH_W-1:0] chan;
        res_t            res;
        logic            last;
    } event_word_t;

    typedef struct packed {
        kind_t            kind;
        logic [CH_W-1:0]  chan;
        logic [SEC_W-1:0] grace;
        logic [SEC_W-1:0] ceiling;
        logic             typed;
        logic [CH_W-1:0]  want_chan;
        res_t             want_res;
    } stim_row_t;

    logic clk = 1'b0;
    logic rst_n;

    debc_in_if  req();
    debc_out_if rsp();

    event_debounce_coalescer uut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .rsp   (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // channel state as the predictor sees it
    logic [TW-1:0]    now_sec;
    logic             ch_active   [NCH];
    logic             ch_pending  [NCH];
    logic [SEC_W-1:0] ch_grace    [NCH];
    logic [SEC_W-1:0] ch_ceiling  [NCH];
    logic [TW-1:0]    ch_fired    [NCH];
    logic [TW-1:0]    ch_touched  [NCH];
    logic [TW-1:0]    ch_deadline [NCH];

    event_word_t expected_events[$];
    int mismatches    = 0;
    int words_checked = 0;
    int items_by_kind [4];
    int res_seen      [8];

    stim_row_t plan [27] = '{
        '{KIND_TICK,   3'd0, 16'd0,      16'd0,      1'b1, 3'd0, RES_IDLE},
        '{KIND_CANCEL, 3'd7, 16'd0,      16'd0,      1'b1, 3'd7, RES_MISS},
        '{KIND_NONE,   3'd5, 16'hFFFF,   16'hFFFF,   1'b1, 3'd5, RES_IDLE},
        '{KIND_SUBMIT, 3'd0, 16'd0,      16'd0,      1'b1, 3'd0, RES_LEAD},
        '{KIND_TICK,   3'd0, 16'd0,      16'd0,      1'b0, 3'd0, RES_IDLE},
        '{KIND_SUBMIT, 3'd1, 16'd2,      16'd3,      1'b1, 3'd1, RES_LEAD},
        '{KIND_SUBMIT, 3'd1, 16'hFFFF,   16'hFFFF,   1'b1, 3'd1, RES_COAL},
        '{KIND_TICK,   3'd0, 16'd0,      16'd0,      1'b0, 3'd0, RES_IDLE},
        '{KIND_SUBMIT, 3'd1, 16'd0,      16'd0,      1'b1, 3'd1, RES_COAL},
        '{KIND_TICK,   3'd0, 16'd0,      16'd0,      1'b0, 3'd0, RES_IDLE},
        '{KIND_SUBMIT, 3'd1, 16'd0,      16'd0,      1'b1, 3'd1, RES_COAL},
        '{KIND_TICK,   3'd0, 16'd0,      16'd0,      1'b0, 3'd0, RES_IDLE},
        '{KIND_SUBMIT, 3'd1, 16'd0,      16'd0,      1'b1, 3'd1, RES_COAL},
        '{KIND_TICK,   3'd0, 16'd0,      16'd0,      1'b0, 3'd0, RES_IDLE},
        '{KIND_TICK,   3'd0, 16'd0,      16'd0,      1'b0, 3'd0, RES_IDLE},
        '{KIND_SUBMIT, 3'd2, 16'hFFFF,   16'hFFFF,   1'b1, 3'd2, RES_LEAD},
        '{KIND_SUBMIT, 3'd3, 16'hFFFF,   16'd0,      1'b1, 3'd3, RES_LEAD},
        '{KIND_SUBMIT, 3'd4, 16'd1,      16'hFFFF,   1'b1, 3'd4, RES_LEAD},
        '{KIND_SUBMIT, 3'd5, 16'hAAAA,   16'h5555,   1'b1, 3'd5, RES_LEAD},
        '{KIND_CANCEL, 3'd2, 16'd0,      16'd0,      1'b1, 3'd2, RES_CANCEL},
        '{KIND_CANCEL, 3'd2, 16'd0,      16'd0,      1'b1, 3'd2, RES_MISS},
        '{KIND_SUBMIT, 3'd4, 16'd0,      16'd0,      1'b1, 3'd4, RES_COAL},
        '{KIND_SUBMIT, 3'd6, 16'd1,      16'd1,      1'b1, 3'd6, RES_LEAD},
        '{KIND_SUBMIT, 3'd6, 16'd0,      16'd0,      1'b1, 3'd6, RES_COAL},
        '{KIND_TICK,   3'd0, 16'd0,      16'd0,      1'b0, 3'd0, RES_IDLE},
        '{KIND_CANCEL, 3'd3, 16'd0,      16'd0,      1'b1, 3'd3, RES_CANCEL},
        '{KIND_CANCEL, 3'd5, 16'd0,      16'd0,      1'b1, 3'd5, RES_CANCEL}
    };

    function automatic event_word_t ev(logic [CH_W-1:0] ch, res_t r, logic l);
        event_word_t w;
        w.chan = ch;
        w.res  = r;
        w.last = l;
        return w;
    endfunction

    function automatic logic is_due(logic [TW-1:0] now, logic [TW-1:0] t);
        logic [TW-1:0] d;
        d = now - t;
        return !d[TW-1];
    endfunction

    function automatic logic [TW-1:0] secs_ahead(logic [TW-1:0] t, logic [TW-1:0] now);
        logic [TW-1:0] d;
        d = t - now;
        return (d == '0 || d[TW-1]) ? TW'(1) : d;
    endfunction

    task automatic rearm_channel(input int c);
        logic [TW-1:0] g;
        logic [TW-1:0] k;
        g = secs_ahead(ch_touched[c] + TW'(ch_grace[c]), now_sec);
        k = secs_ahead(ch_fired[c] + TW'(ch_ceiling[c]), now_sec);
        ch_deadline[c] = now_sec + ((g < k) ? g : k);
    endtask

    task automatic debounce_predict(input kind_t k, input logic [CH_W-1:0] ch,
                                    input logic [SEC_W-1:0] g,
                                    input logic [SEC_W-1:0] c,
                                    output event_word_t fires[$]);
        logic [SEC_W-1:0] gr;
        logic [SEC_W-1:0] cl;
        logic at_g;
        logic at_c;
        fires = {};
        case (k)
            KIND_SUBMIT:
            begin
                if (ch_active[ch])
                begin
                    ch_touched[ch] = now_sec;
                    ch_pending[ch] = 1'b1;
                    fires.push_back(ev(ch, RES_COAL, 1'b1));
                end
                else
                begin
                    gr = (g == '0) ? SEC_W'(1) : g;
                    cl = (c < gr) ? gr : c;
                    ch_active[ch]  = 1'b1;
                    ch_pending[ch] = 1'b0;
                    ch_grace[ch]   = gr;
                    ch_ceiling[ch] = cl;
                    ch_fired[ch]   = now_sec;
                    ch_touched[ch] = now_sec;
                    rearm_channel(ch);
                    fires.push_back(ev(ch, RES_LEAD, 1'b1));
                end
            end
            KIND_CANCEL:
            begin
                if (ch_active[ch])
                begin
                    ch_active[ch]  = 1'b0;
                    ch_pending[ch] = 1'b0;
                    fires.push_back(ev(ch, RES_CANCEL, 1'b1));
                end
                else
                    fires.push_back(ev(ch, RES_MISS, 1'b1));
            end
            KIND_TICK:
            begin
                now_sec = now_sec + 1'b1;
                for (int i = 0; i < NCH; i++)
                begin
                    if (ch_active[i] && is_due(now_sec, ch_deadline[i]))
                    begin
                        at_g = is_due(now_sec, ch_touched[i] + TW'(ch_grace[i]));
                        at_c = is_due(now_sec, ch_fired[i] + TW'(ch_ceiling[i]));
                        if (!ch_pending[i] && at_g)
                            ch_active[i] = 1'b0;
                        else if (ch_pending[i] && at_g)
                        begin
                            ch_active[i]  = 1'b0;
                            ch_pending[i] = 1'b0;
                            fires.push_back(ev(CH_W'(i), RES_TRAIL, 1'b0));
                        end
                        else if (ch_pending[i] && at_c)
                        begin
                            ch_fired[i]   = now_sec;
                            ch_pending[i] = 1'b0;
                            rearm_channel(i);
                            fires.push_back(ev(CH_W'(i), RES_CEIL, 1'b0));
                        end
                        else
                            rearm_channel(i);
                    end
                end
                if (fires.size() == 0)
                    fires.push_back(ev('0, RES_IDLE, 1'b1));
                else
                    fires[fires.size()-1].last = 1'b1;
            end
            default:
                fires.push_back(ev(ch, RES_IDLE, 1'b1));
        endcase
    endtask

    task automatic offer_item(input kind_t k, input logic [CH_W-1:0] ch,
                              input logic [SEC_W-1:0] g, input logic [SEC_W-1:0] c,
                              input logic may_idle, input logic typed,
                              input event_word_t typed_word);
        event_word_t fires[$];
        while (may_idle && $urandom_range(0, 99) < 10)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid           <= 1'b1;
        req.kind            <= k;
        req.channel         <= ch;
        req.grace_seconds   <= g;
        req.ceiling_seconds <= c;
        do
            @(posedge clk);
        while (!req.ready);
        debounce_predict(k, ch, g, c, fires);
        if (typed)
            expected_events.push_back(typed_word);
        else
            foreach (fires[i])
                expected_events.push_back(fires[i]);
        items_by_kind[k]++;
    endtask

    initial
    begin
        int pick;
        kind_t k;
        logic [SEC_W-1:0] g;
        logic [SEC_W-1:0] c;
        now_sec = '0;
        for (int i = 0; i < NCH; i++)
        begin
            ch_active[i]  = 1'b0;
            ch_pending[i] = 1'b0;
        end
        rst_n               <= 1'b0;
        req.valid           <= 1'b0;
        req.kind            <= KIND_SUBMIT;
        req.channel         <= '0;
        req.grace_seconds   <= '0;
        req.ceiling_seconds <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
            offer_item(plan[i].kind, plan[i].chan, plan[i].grace, plan[i].ceiling, 1'b1,
                       plan[i].typed, ev(plan[i].want_chan, plan[i].want_res, 1'b1));

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                k = KIND_TICK;
            else if (pick < 85)
                k = KIND_SUBMIT;
            else if (pick < 95)
                k = KIND_CANCEL;
            else
                k = KIND_NONE;
            g = ($urandom_range(0, 99) < 80) ? SEC_W'($urandom_range(0, 6)) : SEC_W'($urandom());
            c = ($urandom_range(0, 99) < 80) ? SEC_W'($urandom_range(0, 14)) : SEC_W'($urandom());
            offer_item(k, CH_W'($urandom()), g, c, !(n >= 80 && n < 150), 1'b0,
                       ev('0, RES_IDLE, 1'b1));
        end
        req.valid <= 1'b0;

        while (expected_events.size() != 0)
            @(posedge clk);
        repeat (5 * NCH + 20) @(posedge clk);

        $display("items: %0d submit, %0d cancel, %0d tick, %0d unknown kind",
                 items_by_kind[KIND_SUBMIT], items_by_kind[KIND_CANCEL],
                 items_by_kind[KIND_TICK], items_by_kind[KIND_NONE]);
        $display("words: %0d (lead %0d coal %0d trail %0d ceil %0d cancel %0d miss %0d idle %0d)",
                 words_checked, res_seen[RES_LEAD], res_seen[RES_COAL], res_seen[RES_TRAIL],
                 res_seen[RES_CEIL], res_seen[RES_CANCEL], res_seen[RES_MISS],
                 res_seen[RES_IDLE]);
        if (mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        int  cyc;
        logic held;
        cyc  = 0;
        held = 1'b0;
        rsp.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (!held && words_checked >= 120)
            begin
                // hold off long enough for the request side to back up
                held = 1'b1;
                rsp.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            rsp.ready <= (cyc >= 400 && cyc < 1400) || ($urandom_range(0, 99) >= 10);
        end
    end

    always @(posedge clk)
    begin : watch_results
        event_word_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            words_checked++;
            res_seen[rsp.event_res]++;
            if (expected_events.size() == 0)
            begin
                $display("%0t: unexpected word: channel %0d event %0d last %0d",
                         $time, rsp.out_channel, rsp.event_res, rsp.last);
                mismatches++;
            end
            else
            begin
                want = expected_events.pop_front();
                if (rsp.out_channel !== want.chan)
                begin
                    $display("%0t: out_channel expected %0d actual %0d",
                             $time, want.chan, rsp.out_channel);
                    mismatches++;
                end
                if (rsp.event_res !== want.res)
                begin
                    $display("%0t: event_res on channel %0d expected %0d actual %0d",
                             $time, want.chan, want.res, rsp.event_res);
                    mismatches++;
                end
                if (rsp.last !== want.last)
                begin
                    $display("%0t: last on channel %0d expected %0d actual %0d",
                             $time, want.chan, want.last, rsp.last);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        #3ms;
        $display("simulation failed");
        $finish;
    end

endmodule
